// ===== rtl/htd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

  localparam int TOTAL_W   = 31;
  localparam int OUT_SYM_W = 8;
  localparam int OP_W      = 2;
  localparam int ERR_W     = 2;

  localparam logic [OP_W-1:0] OP_CODE   = 2'd0;
  localparam logic [OP_W-1:0] OP_END    = 2'd1;
  localparam logic [OP_W-1:0] OP_STREAM = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_MISS = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_LINK,
    ST_PUSH
  } state_t;

  typedef enum logic [1:0] {
    RES_FULL,
    RES_MISS,
    RES_SYM
  } res_kind_t;

  typedef struct packed {
    logic      capture;
    logic      rd_next;
    logic      bld_step;
    logic      bld_home;
    logic      alloc_clear;
    logic      alloc_link;
    logic      set_sym;
    logic      dec_step;
    logic      dec_home;
    logic      count_down;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            child_zero;
    logic            store_full;
    logic            is_leaf;
    logic            sl_zero;
    logic            out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/htd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htd_datapath
  import htd_pkg::*;
#(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic                 in_bit_value,
  input  wire logic [OUT_SYM_W-1:0] in_symbol_in,
  input  wire logic                 cfg_wr_en,
  input  wire logic [TOTAL_W-1:0]   cfg_wr_data,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUT_SYM_W-1:0]      out_symbol_out,
  output logic                      out_last_symbol,
  output logic [ERR_W-1:0]          out_error_code
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);

  typedef struct packed {
    logic [IW-1:0]          left;
    logic [IW-1:0]          right;
    logic [SYMBOL_BITS-1:0] sym;
  } node_t;

  localparam node_t NODE_EMPTY = '0;

  node_t                  mem [NODE_COUNT];
  node_t                  mem_q_r;
  logic                   rd_root_r;
  node_t                  root_r;
  logic [IW-1:0]          bld_cur_r;
  logic [IW-1:0]          dec_cur_r;
  logic [IW-1:0]          cur_r;
  logic [IW-1:0]          nxt_r;
  logic [CW-1:0]          nfn_r;
  logic [TOTAL_W-1:0]     left_r;
  logic [OP_W-1:0]        op_r;
  logic                   dir_r;
  logic [SYMBOL_BITS-1:0] sym_r;
  logic [OUT_SYM_W-1:0]   res_sym_r;
  logic                   res_last_r;
  logic [ERR_W-1:0]       res_err_r;
  logic                   out_valid_r;
  logic [OUT_SYM_W-1:0]   out_sym_r;
  logic                   out_last_r;
  logic [ERR_W-1:0]       out_err_r;

  node_t         rdata;
  node_t         linked;
  node_t         named;
  node_t         wr_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] child;
  logic [IW-1:0] cap_addr;
  logic [IW-1:0] rd_addr;
  logic          rd_en;

  assign rdata    = rd_root_r ? root_r : mem_q_r;
  assign child    = dir_r ? rdata.right : rdata.left;
  assign cap_addr = (in_op == OP_STREAM) ? dec_cur_r : bld_cur_r;
  assign rd_en    = cmd.capture | cmd.rd_next;
  assign rd_addr  = cmd.rd_next ? child : cap_addr;

  always_comb begin
    linked = rdata;
    if (dir_r) begin
      linked.right = nfn_r[IW-1:0];
    end else begin
      linked.left = nfn_r[IW-1:0];
    end
    named     = rdata;
    named.sym = sym_r;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = NODE_EMPTY;
    if (cmd.alloc_clear) begin
      wr_en   = 1'b1;
      wr_addr = nfn_r[IW-1:0];
    end else if (cmd.alloc_link) begin
      wr_en   = 1'b1;
      wr_data = linked;
    end else if (cmd.set_sym) begin
      wr_en   = 1'b1;
      wr_data = named;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr != '0)) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r   <= mem[rd_addr];
      rd_root_r <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= NODE_EMPTY;
    end else if (wr_en && (wr_addr == '0)) begin
      root_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      dir_r <= in_bit_value;
      sym_r <= SYMBOL_BITS'(in_symbol_in);
      cur_r <= cap_addr;
    end
    if (cmd.rd_next) begin
      nxt_r <= child;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bld_cur_r <= '0;
      dec_cur_r <= '0;
      nfn_r     <= CW'(1);
      left_r    <= '0;
    end else begin
      if (cmd.bld_step) begin
        bld_cur_r <= child;
      end else if (cmd.alloc_link) begin
        bld_cur_r <= nfn_r[IW-1:0];
      end else if (cmd.bld_home) begin
        bld_cur_r <= '0;
      end
      if (cmd.alloc_link) begin
        nfn_r <= nfn_r + CW'(1);
      end
      if (cmd.dec_step) begin
        dec_cur_r <= nxt_r;
      end else if (cmd.dec_home) begin
        dec_cur_r <= '0;
      end
      if (cfg_wr_en) begin
        left_r <= cfg_wr_data;
      end else if (cmd.count_down) begin
        left_r <= left_r - TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_kind)
        RES_SYM: begin
          res_sym_r  <= OUT_SYM_W'(rdata.sym);
          res_last_r <= (left_r == TOTAL_W'(1));
          res_err_r  <= ERR_NONE;
        end
        RES_MISS: begin
          res_sym_r  <= '0;
          res_last_r <= 1'b0;
          res_err_r  <= ERR_MISS;
        end
        default: begin
          res_sym_r  <= '0;
          res_last_r <= 1'b0;
          res_err_r  <= ERR_FULL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sym_r  <= res_sym_r;
      out_last_r <= res_last_r;
      out_err_r  <= res_err_r;
    end
  end

  assign sts.op         = op_r;
  assign sts.child_zero = (child == '0);
  assign sts.store_full = (nfn_r == CW'(NODE_COUNT));
  assign sts.is_leaf    = (rdata.left == '0) && (rdata.right == '0);
  assign sts.sl_zero    = (left_r == '0);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_symbol_out  = out_sym_r;
  assign out_last_symbol = out_last_r;
  assign out_error_code  = out_err_r;

endmodule

`default_nettype wire

// ===== rtl/htd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htd_ctrl
  import htd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] in_op,
  output logic                 in_stall,
  input  wire sts_t            sts,
  output cmd_t                 cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   take;

  assign take = in_valid &&
                ((in_op == OP_CODE) || (in_op == OP_END) ||
                 ((in_op == OP_STREAM) && !sts.sl_zero));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        unique case (sts.op)
          OP_CODE: begin
            if (!sts.child_zero) begin
              state_nxt = ST_IDLE;
            end else if (sts.store_full) begin
              state_nxt = ST_PUSH;
            end else begin
              state_nxt = ST_LINK;
            end
          end
          OP_STREAM: begin
            state_nxt = sts.child_zero ? ST_PUSH : ST_RD2;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RD2: begin
        state_nxt = sts.is_leaf ? ST_PUSH : ST_IDLE;
      end
      ST_LINK: begin
        state_nxt = ST_IDLE;
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = take;
      end
      ST_RD1: begin
        unique case (sts.op)
          OP_CODE: begin
            if (!sts.child_zero) begin
              cmd.bld_step = 1'b1;
            end else if (sts.store_full) begin
              cmd.bld_home = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_FULL;
            end else begin
              cmd.alloc_clear = 1'b1;
            end
          end
          OP_END: begin
            cmd.set_sym  = 1'b1;
            cmd.bld_home = 1'b1;
          end
          OP_STREAM: begin
            if (sts.child_zero) begin
              cmd.dec_home = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_MISS;
            end else begin
              cmd.rd_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ST_RD2: begin
        if (sts.is_leaf) begin
          cmd.dec_home   = 1'b1;
          cmd.count_down = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_kind   = RES_SYM;
        end else begin
          cmd.dec_step = 1'b1;
        end
      end
      ST_LINK: begin
        cmd.alloc_link = 1'b1;
      end
      ST_PUSH: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/huffman_tree_decoder_unit.sv =====
// Bit-serial prefix-code decoder walking a binary code tree held in a node memory.
// Input channel (in_valid/in_stall): op 0 adds one code bit on the build path,
// op 1 names the node reached with in_symbol_in, op 2 feeds one stream bit.
// Result channel (out_valid/out_stall): one transfer per decoded symbol, per
// missing-child error and per node-store-full error; nothing for other items.
// cfg_wr_en/cfg_wr_data load the symbol count; write only while the block idles.
// Items are taken one at a time. An ignored item (undefined op, or a stream bit once
// the count is spent) is dropped without being captured. Every other item first
// reads its node: a code bit that follows an existing child and an end-of-code item
// end there, a code bit that allocates a node then links it, a stream bit then reads
// the child node, and a missing-child or store-full error, or a symbol decoded at a
// leaf, is then moved from the result register into the output register.
// Each tree step is one read of the node memory, so the memory read
// loop sets the rate. After reset the tree holds only an empty root, the symbol
// count is zero (stream bits are dropped) and no item is refused. A stalled
// receiver holds the result; the next result then waits inside and in_stall stays
// high until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_decoder_unit
  import htd_pkg::*;
#(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      in_op,
  input  wire logic                 in_bit_value,
  input  wire logic [OUT_SYM_W-1:0] in_symbol_in,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [OUT_SYM_W-1:0]      out_symbol_out,
  output logic                      out_last_symbol,
  output logic [ERR_W-1:0]          out_error_code,
  input  wire logic                 cfg_wr_en,
  input  wire logic [TOTAL_W-1:0]   cfg_wr_data
);

  cmd_t cmd;
  sts_t sts;

  htd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  htd_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_bit_value    (in_bit_value),
    .in_symbol_in    (in_symbol_in),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol_out  (out_symbol_out),
    .out_last_symbol (out_last_symbol),
    .out_error_code  (out_error_code)
  );

endmodule

`default_nettype wire
